// ----- rtl/blpg_pkg.sv -----
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and constants of the line pixel generator
// Register map, command codes, configuration and pixel-stage structs, and
// the color packing used for the framebuffer word.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int CURSOR_W        = 16;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int PIX_SHIFT       = $clog2(BYTES_PER_PIXEL);
  localparam int SCREEN_W        = 13;
  localparam int STRIDE_W        = 16;
  localparam int ADDR_W          = 32;
  localparam int COLOR_W         = 24;
  localparam int WORD_W          = 32;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH       = 3'd0,
    REG_SCREEN_HEIGHT      = 3'd1,
    REG_BASE_OFFSET        = 3'd2,
    REG_LINE_STRIDE        = 3'd3,
    REG_WINDOW_LOW_CORNER  = 3'd4,
    REG_WINDOW_HIGH_CORNER = 3'd5,
    REG_WINDOW_COLOR       = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  localparam logic [SCREEN_W-1:0] RESET_SCREEN_WIDTH  = 13'd640;
  localparam logic [SCREEN_W-1:0] RESET_SCREEN_HEIGHT = 13'd480;
  localparam logic [STRIDE_W-1:0] RESET_LINE_STRIDE   = 16'd2560;
  localparam logic [COLOR_W-1:0]  RESET_WINDOW_COLOR  = 24'h00FFFF;

  typedef struct packed {
    logic [SCREEN_W-1:0]        screen_width;
    logic [SCREEN_W-1:0]        screen_height;
    logic [ADDR_W-1:0]          base_offset;
    logic [STRIDE_W-1:0]        line_stride;
    logic signed [CURSOR_W-1:0] win_lo_x;
    logic signed [CURSOR_W-1:0] win_lo_y;
    logic signed [CURSOR_W-1:0] win_hi_x;
    logic signed [CURSOR_W-1:0] win_hi_y;
    logic [COLOR_W-1:0]         window_color;
  } cfg_t;

  // One traced pixel on its way to the address stage.
  typedef struct packed {
    logic                valid;
    logic                on;
    logic                last;
    logic [SCREEN_W-1:0] x;
    logic [SCREEN_W-1:0] y;
    logic [COLOR_W-1:0]  color;
  } pixel_t;

  // Red/green/blue in, blue/green/red/alpha-zero word out.
  function automatic logic [WORD_W-1:0] color_word(input logic [COLOR_W-1:0] rgb);
    color_word = {rgb[7:0], rgb[15:8], rgb[23:16], 8'h00};
  endfunction

endpackage

// ----- rtl/blpg_line_setup.sv -----
// ----------------------------------------------------------------------------
// blpg_line_setup: line command decode
// Classifies the endpoint deltas into one of eight octants, picks the trace
// origin and builds the deltas and initial error term of the trace.
// ----------------------------------------------------------------------------
module blpg_line_setup #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [blpg_pkg::CURSOR_W-1:0] start_x,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] start_y,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] end_x,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] end_y,
  output logic signed [blpg_pkg::CURSOR_W-1:0] org_x,
  output logic signed [blpg_pkg::CURSOR_W-1:0] org_y,
  output logic signed [blpg_pkg::CURSOR_W-1:0] stop_major,
  output logic        [COORD_BITS:0]           delta_major,
  output logic        [COORD_BITS:0]           delta_minor,
  output logic signed [COORD_BITS+3:0]         error_init,
  output logic                                 major_is_y,
  output logic                                 minor_negative
);
  import blpg_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 4;

  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic signed [DW-1:0]         dx, dy, ndx, ndy;
  logic                         dx_neg, dy_neg, dx_pos, dy_pos;
  logic [DW-1:0]                adx, ady;
  logic                         swap;
  logic signed [COORD_BITS-1:0] fx, fy, tx, ty;

  assign ax = start_x[COORD_BITS-1:0];
  assign ay = start_y[COORD_BITS-1:0];
  assign bx = end_x[COORD_BITS-1:0];
  assign by = end_y[COORD_BITS-1:0];

  assign dx  = DW'(bx) - DW'(ax);
  assign dy  = DW'(by) - DW'(ay);
  assign ndx = -dx;
  assign ndy = -dy;

  assign dx_neg = dx[DW-1];
  assign dy_neg = dy[DW-1];
  assign dx_pos = !dx_neg && (dx != ndx);
  assign dy_pos = !dy_neg && (dy != ndy);

  // Octant order 0..7; octants 3 to 6 trace from the second endpoint.
  always_comb begin
    swap           = 1'b0;
    major_is_y     = 1'b0;
    minor_negative = 1'b0;
    if (!dy_neg && (dy < dx)) begin
      swap = 1'b0;
    end else if (dx_pos && (dx <= dy)) begin
      major_is_y = 1'b1;
    end else if (!dx_pos && (dx > ndy)) begin
      major_is_y     = 1'b1;
      minor_negative = 1'b1;
    end else if (dy_pos && (dy <= ndx)) begin
      swap           = 1'b1;
      minor_negative = 1'b1;
    end else if (!dy_pos && (dy > dx)) begin
      swap = 1'b1;
    end else if (dx_neg && (dx >= dy)) begin
      swap       = 1'b1;
      major_is_y = 1'b1;
    end else if (!dx_neg && (dx < ndy)) begin
      swap           = 1'b1;
      major_is_y     = 1'b1;
      minor_negative = 1'b1;
    end else begin
      minor_negative = 1'b1;
    end
  end

  // After the octant fold both deltas are plain magnitudes.
  assign adx = dx_neg ? ndx : dx;
  assign ady = dy_neg ? ndy : dy;

  assign delta_major = major_is_y ? ady : adx;
  assign delta_minor = major_is_y ? adx : ady;
  assign error_init  = EW'({2'b00, delta_minor, 1'b0}) - EW'({3'b000, delta_major});

  assign fx = swap ? bx : ax;
  assign fy = swap ? by : ay;
  assign tx = swap ? ax : bx;
  assign ty = swap ? ay : by;

  assign org_x      = CURSOR_W'(fx);
  assign org_y      = CURSOR_W'(fy);
  assign stop_major = major_is_y ? CURSOR_W'(ty) : CURSOR_W'(tx);

endmodule

// ----- rtl/blpg_tracer.sv -----
// ----------------------------------------------------------------------------
// blpg_tracer: Bresenham step engine
// Holds the trace state, emits one pixel per tick into the pixel register
// with its on-screen and window tests, and advances the cursor.
// ----------------------------------------------------------------------------
module blpg_tracer #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  blpg_pkg::cfg_t                       cfg,
  input  logic                                 in_fire,
  input  blpg_pkg::op_t                        op,
  input  logic        [blpg_pkg::COLOR_W-1:0]  line_color,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] org_x,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] org_y,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] stop_in,
  input  logic        [COORD_BITS:0]           dmaj_in,
  input  logic        [COORD_BITS:0]           dmin_in,
  input  logic signed [COORD_BITS+3:0]         error_in,
  input  logic                                 major_y_in,
  input  logic                                 minor_neg_in,
  input  logic                                 pix_ready,
  output blpg_pkg::pixel_t                     pix
);
  import blpg_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 4;

  logic signed [CURSOR_W-1:0] cursor_x, cursor_y, stop_major;
  logic signed [EW-1:0]       error_term;
  logic [DW-1:0]              delta_major, delta_minor;
  logic                       minor_negative, major_is_y, line_active;
  logic [COLOR_W-1:0]         draw_color;

  logic                       start_fire, tick_fire, last_now, on_now, inside_now, err_pos;
  logic signed [CURSOR_W-1:0] major_now, cursor_x_next, cursor_y_next, minor_step;
  logic signed [EW-1:0]       two_min, two_maj, error_next;
  logic                       line_active_next;

  assign start_fire = in_fire && (op == OP_START);
  assign tick_fire  = in_fire && (op == OP_TICK) && line_active;

  assign major_now = major_is_y ? cursor_y : cursor_x;
  assign last_now  = (major_now == stop_major);

  assign on_now = !cursor_x[CURSOR_W-1] && !cursor_y[CURSOR_W-1] &&
                  (cursor_x[CURSOR_W-2:0] < {2'b00, cfg.screen_width}) &&
                  (cursor_y[CURSOR_W-2:0] < {2'b00, cfg.screen_height});

  assign inside_now = (cursor_x > cfg.win_lo_x) && (cursor_x < cfg.win_hi_x) &&
                      (cursor_y > cfg.win_lo_y) && (cursor_y < cfg.win_hi_y);

  // Error update: subtract 2*dmajor on a minor step, always add 2*dminor.
  assign two_min    = EW'({2'b00, delta_minor, 1'b0});
  assign two_maj    = EW'({2'b00, delta_major, 1'b0});
  assign err_pos    = !error_term[EW-1] && (error_term != '0);
  assign error_next = error_term + two_min - (err_pos ? two_maj : EW'(0));
  assign minor_step = minor_negative ? CURSOR_W'(-1) : CURSOR_W'(1);

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    if (major_is_y) begin
      cursor_y_next = cursor_y + CURSOR_W'(1);
      if (err_pos) begin
        cursor_x_next = cursor_x + minor_step;
      end
    end else begin
      cursor_x_next = cursor_x + CURSOR_W'(1);
      if (err_pos) begin
        cursor_y_next = cursor_y + minor_step;
      end
    end
  end

  always_comb begin
    line_active_next = line_active;
    if (start_fire) begin
      line_active_next = 1'b1;
    end else if (tick_fire && last_now) begin
      line_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      pix.valid   <= 1'b0;
    end else begin
      line_active <= line_active_next;
      if (pix_ready) begin
        pix.valid <= tick_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      cursor_x       <= org_x;
      cursor_y       <= org_y;
      stop_major     <= stop_in;
      delta_major    <= dmaj_in;
      delta_minor    <= dmin_in;
      error_term     <= error_in;
      major_is_y     <= major_y_in;
      minor_negative <= minor_neg_in;
      draw_color     <= line_color;
    end else if (tick_fire) begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      error_term <= error_next;
    end
    if (tick_fire) begin
      pix.on    <= on_now;
      pix.last  <= last_now;
      pix.x     <= cursor_x[SCREEN_W-1:0];
      pix.y     <= cursor_y[SCREEN_W-1:0];
      pix.color <= inside_now ? cfg.window_color : draw_color;
    end
  end

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    start_fire |=> line_active)
    else $error("line not armed after start command");

  a_last_disarms: assert property (@(posedge clk) disable iff (rst)
    (tick_fire && last_now) |=> !line_active)
    else $error("line still armed after its final pixel");

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix_ready) |=> (pix.valid && $stable(pix)))
    else $error("pixel register changed while the address stage was full");

endmodule

// ----- rtl/blpg_pixel_out.sv -----
// ----------------------------------------------------------------------------
// blpg_pixel_out: address and word stage
// Turns a traced pixel into its framebuffer byte address and color word and
// holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module blpg_pixel_out (
  input  logic                            clk,
  input  logic                            rst,
  input  blpg_pkg::cfg_t                  cfg,
  input  blpg_pkg::pixel_t                pix,
  input  logic                            out_stall,
  output logic                            ready,
  output logic                            out_valid,
  output logic [blpg_pkg::ADDR_W-1:0]     pixel_address,
  output logic [blpg_pkg::WORD_W-1:0]     pixel_word,
  output logic                            write_enable,
  output logic                            last
);
  import blpg_pkg::*;

  logic [SCREEN_W+STRIDE_W-1:0] row_off;
  logic [ADDR_W-1:0]            addr_calc;

  assign ready     = !out_valid || !out_stall;
  assign row_off   = pix.y * cfg.line_stride;
  assign addr_calc = ADDR_W'(row_off) + ADDR_W'({pix.x, {PIX_SHIFT{1'b0}}}) +
                     cfg.base_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= pix.valid;
    end
  end

  // Off-screen pixels carry zero address and word.
  always_ff @(posedge clk) begin
    if (ready && pix.valid) begin
      pixel_address <= pix.on ? addr_calc : '0;
      pixel_word    <= pix.on ? color_word(pix.color) : '0;
      write_enable  <= pix.on;
      last          <= pix.last;
    end
  end

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (pixel_address == '0 && pixel_word == '0))
    else $error("off-screen pixel carries a nonzero address or word");

endmodule

// ----- rtl/bresenham_line_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator: eight-octant line rasterizer
// Start commands arm a trace; every tick transfer yields one framebuffer pixel.
// ----------------------------------------------------------------------------
// A start transfer (op 0) latches both endpoints and the line color and yields
// no result; each following tick transfer (op 1) yields one pixel: its byte
// address x*4 + y*line_stride + base_offset, its color word, write_enable
// (low and address/word zero when off screen) and last on the final pixel.
// Ticks with no line armed are absorbed silently. The block takes one transfer
// per clock while in_stall is low: the Bresenham step closes over the trace
// registers, the row multiply sits in a second register stage, and a tick's
// pixel passes the pixel register, then the output register. Pixels stream
// out at one per clock while stall is low. Configuration writes take effect
// on the next clock and must happen only while no pixel is in flight.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [blpg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [blpg_pkg::CFG_DATA_W-1:0]      cfg_data,
  // command channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] start_x,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] start_y,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] end_x,
  input  logic signed [blpg_pkg::CURSOR_W-1:0] end_y,
  input  logic [blpg_pkg::COLOR_W-1:0]         line_color,
  // pixel channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [blpg_pkg::ADDR_W-1:0]          pixel_address,
  output logic [blpg_pkg::WORD_W-1:0]          pixel_word,
  output logic                                 write_enable,
  output logic                                 last
);
  import blpg_pkg::*;

  cfg_t   cfg;
  pixel_t pix;
  logic   out_ready, pix_ready, in_fire;

  logic signed [CURSOR_W-1:0] org_x, org_y, stop_major;
  logic [COORD_BITS:0]        delta_major, delta_minor;
  logic signed [COORD_BITS+3:0] error_init;
  logic                       major_is_y, minor_negative;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RESET_SCREEN_WIDTH;
      cfg.screen_height <= RESET_SCREEN_HEIGHT;
      cfg.base_offset   <= '0;
      cfg.line_stride   <= RESET_LINE_STRIDE;
      cfg.win_lo_x      <= '0;
      cfg.win_lo_y      <= '0;
      cfg.win_hi_x      <= '0;
      cfg.win_hi_y      <= '0;
      cfg.window_color  <= RESET_WINDOW_COLOR;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:       cfg.screen_width  <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT:      cfg.screen_height <= cfg_data[SCREEN_W-1:0];
        REG_BASE_OFFSET:        cfg.base_offset   <= cfg_data[ADDR_W-1:0];
        REG_LINE_STRIDE:        cfg.line_stride   <= cfg_data[STRIDE_W-1:0];
        REG_WINDOW_LOW_CORNER: begin
          cfg.win_lo_x <= cfg_data[31:16];
          cfg.win_lo_y <= cfg_data[15:0];
        end
        REG_WINDOW_HIGH_CORNER: begin
          cfg.win_hi_x <= cfg_data[31:16];
          cfg.win_hi_y <= cfg_data[15:0];
        end
        REG_WINDOW_COLOR:       cfg.window_color  <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Back-pressure: the pixel register advances when the output register is
  // free or being drained; hold commands only when both stages are full.
  assign pix_ready = !pix.valid || out_ready;
  assign in_stall  = !pix_ready;
  assign in_fire   = in_valid && !in_stall;

  blpg_line_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .org_x          (org_x),
    .org_y          (org_y),
    .stop_major     (stop_major),
    .delta_major    (delta_major),
    .delta_minor    (delta_minor),
    .error_init     (error_init),
    .major_is_y     (major_is_y),
    .minor_negative (minor_negative)
  );

  blpg_tracer #(
    .COORD_BITS(COORD_BITS)
  ) u_tracer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_fire      (in_fire),
    .op           (op_t'(op)),
    .line_color   (line_color),
    .org_x        (org_x),
    .org_y        (org_y),
    .stop_in      (stop_major),
    .dmaj_in      (delta_major),
    .dmin_in      (delta_minor),
    .error_in     (error_init),
    .major_y_in   (major_is_y),
    .minor_neg_in (minor_negative),
    .pix_ready    (pix_ready),
    .pix          (pix)
  );

  blpg_pixel_out u_pixel_out (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pix           (pix),
    .out_stall     (out_stall),
    .ready         (out_ready),
    .out_valid     (out_valid),
    .pixel_address (pixel_address),
    .pixel_word    (pixel_word),
    .write_enable  (write_enable),
    .last          (last)
  );

endmodule
